@@ rtl/tpc_pkg.sv @@
package tpc_pkg;

    localparam int TIME_W   = 48;
    localparam int MV_W     = 16;
    localparam int POS_W    = 10;
    localparam int ALPHA_W  = 10;
    localparam int RATE_W   = 24;
    localparam int CNT8_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int DIVD_W = 30;
    localparam int DIVS_W = TIME_W;
    localparam int DCNT_W = $clog2(DIVD_W + 1);

    localparam int ACC_W = 20;

    localparam logic [CNT8_W-1:0] NOISE_LIMIT = 8'd3;
    localparam logic [CNT8_W-1:0] STUCK_LIMIT = 8'd64;
    localparam logic [POS_W-1:0]  SAFE_POSITION = 10'd0;
    localparam logic [TIME_W-1:0] STALE_LIMIT_US = 48'd100000;
    localparam logic [POS_W-1:0]  FULL_SCALE = 10'd1000;
    localparam logic [19:0]       US_PER_S = 20'd1000000;

    typedef enum logic [3:0] {
        F_NONE   = 4'd0,
        F_CONFIG = 4'd1,
        F_COMMS  = 4'd2,
        F_GROUND = 4'd3,
        F_SUPPLY = 4'd4,
        F_RATE   = 4'd5,
        F_NOISE  = 4'd6,
        F_STUCK  = 4'd7,
        F_STALE  = 4'd8
    } fault_t;

    typedef enum logic [1:0] {
        H_VALID    = 2'd0,
        H_DEGRADED = 2'd1,
        H_STALE    = 2'd2,
        H_FAILED   = 2'd3
    } health_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        R_CLOSED = 3'd0,
        R_OPEN   = 3'd1,
        R_MIN    = 3'd2,
        R_MAX    = 3'd3,
        R_ALPHA  = 3'd4,
        R_RATE   = 3'd5,
        R_STUCK  = 3'd6,
        R_NOISE  = 3'd7
    } reg_idx_t;

    function automatic health_t health_of(fault_t f);
        health_t h;
        case (f)
            F_NONE:  h = H_VALID;
            F_RATE:  h = H_DEGRADED;
            F_NOISE: h = H_DEGRADED;
            F_STUCK: h = H_DEGRADED;
            F_STALE: h = H_STALE;
            default: h = H_FAILED;
        endcase
        return h;
    endfunction

    function automatic logic [CNT8_W-1:0] sat_inc(logic [CNT8_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

@@ rtl/tpc_div.sv @@
module tpc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tpc_pkg::DIVD_W-1:0]  dividend,
    input  logic [tpc_pkg::DIVS_W-1:0]  divisor,
    output logic                        busy,
    output logic                        done,
    output logic [tpc_pkg::DIVD_W-1:0]  quotient
);
    import tpc_pkg::*;

    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] rem_next;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign rem_next = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DCNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/throttle_position_conditioner.sv @@
// Path: a staleness query or a fault found in the first check passes S_IDLE, S_CHECK
// and S_EMIT, which loads the output register once it is free or being taken; a sample
// through the filter also takes up to three 30-step serial divisions on the shared divider.
// Throughput: one item at a time; the next item is taken the cycle after the result
// enters the output register, which holds it while the next item is processed.
// Reset: asynchronous, active low; registers take their reset values, all history is cleared.
module throttle_position_conditioner (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [tpc_pkg::TIME_W-1:0]      time_us,
    input  logic                            sample_ok,
    input  logic                            mv_valid,
    input  logic [tpc_pkg::MV_W-1:0]        millivolts,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tpc_pkg::POS_W-1:0]       position_permille,
    output logic                            fallback_flag,
    output logic                            control_ok,
    output logic [1:0]                      health,
    output logic [3:0]                      fault_code,
    output logic [tpc_pkg::TIME_W-1:0]      reading_time,
    input  logic                            cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import tpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SCALE, S_SCALE_DIV, S_RATE, S_RATE_DIV,
        S_HIST, S_FILT_MUL, S_FILT_ADD, S_FILT_DIV, S_EMIT
    } state_t;

    state_t state_reg;

    logic [MV_W-1:0]    closed_reg, open_reg, min_reg, max_reg, stuck_reg, noise_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [RATE_W-1:0]  rate_reg;

    logic               op_reg;
    logic [TIME_W-1:0]  t_reg;
    logic               ok_reg;
    logic [MV_W-1:0]    mv_reg;
    logic [POS_W-1:0]   perm_reg;
    logic [ACC_W-1:0]   acc_reg;

    logic [TIME_W-1:0]  last_sample_time_reg, last_good_time_reg;
    logic [POS_W-1:0]   last_good_pos_reg;
    logic [MV_W-1:0]    last_good_mv_reg;
    logic signed [MV_W:0] last_good_delta_reg;
    logic               have_reg;
    logic [CNT8_W-1:0]  repeat_reg, noise_cnt_reg;
    logic [POS_W-1:0]   filter_reg;
    logic               started_reg;

    logic [POS_W-1:0]   lr_pos_reg;
    logic               lr_fb_reg, lr_vfc_reg;
    health_t            lr_health_reg;
    fault_t             lr_fault_reg;
    logic [TIME_W-1:0]  lr_time_reg;

    logic               out_valid_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic               out_fb_reg, out_vfc_reg;
    health_t            out_health_reg;
    fault_t             out_fault_reg;
    logic [TIME_W-1:0]  out_time_reg;

    logic               div_start, div_busy, div_done;
    logic [DIVD_W-1:0]  div_dividend, div_quotient;
    logic [DIVS_W-1:0]  div_divisor;

    logic               cfg_ok, stale, rate_on, noise_on, sig, rev;
    logic [TIME_W-1:0]  dt;
    logic [POS_W-1:0]   dp;
    logic signed [MV_W:0] d;
    logic [MV_W:0]      absd;
    logic [CNT8_W-1:0]  next_noise, next_rep;
    fault_t             fault_sel;
    logic               commit;
    logic [POS_W-1:0]   commit_fv;
    logic [DIVD_W-1:0]  scale_num, rate_num;
    logic [ACC_W:0]     filt_sum;

    assign cfg_ok = (open_reg > closed_reg) && (min_reg <= closed_reg)
                 && (max_reg >= open_reg) && (alpha_reg <= FULL_SCALE);
    assign stale  = !have_reg || ((t_reg - last_sample_time_reg) > STALE_LIMIT_US);
    assign dt     = t_reg - last_good_time_reg;
    assign rate_on = have_reg && (rate_reg != '0) && (t_reg > last_good_time_reg);
    assign dp     = (perm_reg > last_good_pos_reg) ? perm_reg - last_good_pos_reg
                                                   : last_good_pos_reg - perm_reg;
    assign d      = $signed({1'b0, mv_reg}) - $signed({1'b0, last_good_mv_reg});
    assign absd   = d[MV_W] ? 17'(-d) : 17'(d);
    assign noise_on = have_reg && (noise_reg != '0) && (NOISE_LIMIT != '0);
    assign sig    = absd >= {1'b0, noise_reg};
    assign rev    = (d > 0 && last_good_delta_reg < 0) || (d < 0 && last_good_delta_reg > 0);
    assign next_noise = !noise_on ? '0 : (sig ? (rev ? sat_inc(noise_cnt_reg) : 8'd1) : '0);
    assign next_rep   = !have_reg ? 8'd1
                      : ((absd <= {1'b0, stuck_reg}) ? sat_inc(repeat_reg) : 8'd1);

    assign scale_num = DIVD_W'(27'((mv_reg - closed_reg) * FULL_SCALE));
    assign rate_num  = DIVD_W'(dp * US_PER_S);
    assign filt_sum  = {1'b0, acc_reg} + 21'((FULL_SCALE - alpha_reg) * filter_reg);

    always_comb
    begin
        fault_sel = F_NONE;
        case (state_reg)
            S_CHECK:
            begin
                if (op_reg)
                    fault_sel = stale ? F_STALE : F_NONE;
                else if (!cfg_ok)
                    fault_sel = F_CONFIG;
                else if (!ok_reg)
                    fault_sel = F_COMMS;
                else if (mv_reg < min_reg)
                    fault_sel = F_GROUND;
                else if (mv_reg > max_reg)
                    fault_sel = F_SUPPLY;
            end
            S_RATE_DIV:
                if (div_done && (div_quotient > {6'b0, rate_reg}))
                    fault_sel = F_RATE;
            S_HIST:
            begin
                if (noise_on && next_noise >= NOISE_LIMIT)
                    fault_sel = F_NOISE;
                else if (have_reg && STUCK_LIMIT != '0 && next_rep >= STUCK_LIMIT)
                    fault_sel = F_STUCK;
            end
            default: fault_sel = F_NONE;
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = scale_num;
        div_divisor  = TIME_W'(open_reg - closed_reg);
        case (state_reg)
            S_SCALE: div_start = 1'b1;
            S_RATE:
            begin
                div_start    = rate_on;
                div_dividend = rate_num;
                div_divisor  = dt;
            end
            S_FILT_ADD:
            begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'(filt_sum);
                div_divisor  = TIME_W'(FULL_SCALE);
            end
            default: div_start = 1'b0;
        endcase
    end

    assign commit = ((state_reg == S_HIST) && fault_sel == F_NONE && !started_reg)
                 || ((state_reg == S_FILT_DIV) && div_done);
    assign commit_fv = (state_reg == S_HIST) ? perm_reg : div_quotient[POS_W-1:0];

    tpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= 16'd500;
            open_reg   <= 16'd4500;
            min_reg    <= 16'd200;
            max_reg    <= 16'd4800;
            alpha_reg  <= 10'd200;
            rate_reg   <= '0;
            stuck_reg  <= '0;
            noise_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                R_CLOSED: closed_reg <= cfg_wdata[MV_W-1:0];
                R_OPEN:   open_reg   <= cfg_wdata[MV_W-1:0];
                R_MIN:    min_reg    <= cfg_wdata[MV_W-1:0];
                R_MAX:    max_reg    <= cfg_wdata[MV_W-1:0];
                R_ALPHA:  alpha_reg  <= cfg_wdata[ALPHA_W-1:0];
                R_RATE:   rate_reg   <= cfg_wdata[RATE_W-1:0];
                R_STUCK:  stuck_reg  <= cfg_wdata[MV_W-1:0];
                R_NOISE:  noise_reg  <= cfg_wdata[MV_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg <= op;
            t_reg  <= time_us;
            ok_reg <= sample_ok & mv_valid;
            mv_reg <= millivolts;
        end
        if (state_reg == S_CHECK)
            perm_reg <= '0;
        else if (state_reg == S_SCALE_DIV && div_done)
            perm_reg <= (div_quotient > DIVD_W'(FULL_SCALE)) ? FULL_SCALE
                                                             : div_quotient[POS_W-1:0];
        if (state_reg == S_FILT_MUL)
            acc_reg <= ACC_W'(alpha_reg * perm_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            last_sample_time_reg <= '0;
            last_good_time_reg   <= '0;
            last_good_pos_reg    <= '0;
            last_good_mv_reg     <= '0;
            last_good_delta_reg  <= '0;
            have_reg             <= 1'b0;
            repeat_reg           <= '0;
            noise_cnt_reg        <= '0;
            filter_reg           <= '0;
            started_reg          <= 1'b0;
            lr_pos_reg           <= '0;
            lr_fb_reg            <= 1'b0;
            lr_vfc_reg           <= 1'b0;
            lr_health_reg        <= H_VALID;
            lr_fault_reg         <= F_NONE;
            lr_time_reg          <= '0;
            out_valid_reg        <= 1'b0;
            out_pos_reg          <= '0;
            out_fb_reg           <= 1'b0;
            out_vfc_reg          <= 1'b0;
            out_health_reg       <= H_VALID;
            out_fault_reg        <= F_NONE;
            out_time_reg         <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;

            if (fault_sel != F_NONE)
            begin
                lr_pos_reg    <= SAFE_POSITION;
                lr_fb_reg     <= 1'b1;
                lr_vfc_reg    <= 1'b0;
                lr_health_reg <= health_of(fault_sel);
                lr_fault_reg  <= fault_sel;
                lr_time_reg   <= t_reg;
                if (fault_sel == F_NOISE)
                    noise_cnt_reg <= next_noise;
                if (fault_sel == F_STUCK)
                    repeat_reg <= next_rep;
            end

            if (commit)
            begin
                filter_reg           <= commit_fv;
                started_reg          <= 1'b1;
                last_sample_time_reg <= t_reg;
                last_good_time_reg   <= t_reg;
                last_good_pos_reg    <= perm_reg;
                last_good_mv_reg     <= mv_reg;
                last_good_delta_reg  <= have_reg ? d : '0;
                have_reg             <= 1'b1;
                repeat_reg           <= next_rep;
                noise_cnt_reg        <= next_noise;
                lr_pos_reg           <= commit_fv;
                lr_fb_reg            <= 1'b0;
                lr_vfc_reg           <= 1'b1;
                lr_health_reg        <= H_VALID;
                lr_fault_reg         <= F_NONE;
                lr_time_reg          <= t_reg;
            end

            case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (fault_sel != F_NONE || op_reg)
                        state_reg <= S_EMIT;
                    else if (mv_reg <= closed_reg)
                        state_reg <= S_RATE;
                    else
                        state_reg <= S_SCALE;
                end
                S_SCALE:
                    state_reg <= S_SCALE_DIV;
                S_SCALE_DIV:
                    if (div_done)
                        state_reg <= S_RATE;
                S_RATE:
                    state_reg <= rate_on ? S_RATE_DIV : S_HIST;
                S_RATE_DIV:
                    if (div_done)
                        state_reg <= (fault_sel != F_NONE) ? S_EMIT : S_HIST;
                S_HIST:
                begin
                    if (fault_sel != F_NONE || !started_reg)
                        state_reg <= S_EMIT;
                    else
                        state_reg <= S_FILT_MUL;
                end
                S_FILT_MUL:
                    state_reg <= S_FILT_ADD;
                S_FILT_ADD:
                    state_reg <= S_FILT_DIV;
                S_FILT_DIV:
                    if (div_done)
                        state_reg <= S_EMIT;
                S_EMIT:
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_pos_reg    <= lr_pos_reg;
                        out_fb_reg     <= lr_fb_reg;
                        out_vfc_reg    <= lr_vfc_reg;
                        out_health_reg <= lr_health_reg;
                        out_fault_reg  <= lr_fault_reg;
                        out_time_reg   <= lr_time_reg;
                        state_reg      <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign position_permille = out_pos_reg;
    assign fallback_flag     = out_fb_reg;
    assign control_ok        = out_vfc_reg;
    assign health            = out_health_reg;
    assign fault_code        = out_fault_reg;
    assign reading_time      = out_time_reg;

`ifndef ASSERT_OFF
    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fallback_flag |-> !control_ok
            && position_permille == SAFE_POSITION)
        else $error("fallback item carries a control position");

    a_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && control_ok |-> health == H_VALID && fault_code == F_NONE
            && position_permille <= FULL_SCALE)
        else $error("good item carries a fault");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_filter_hist: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> have_reg)
        else $error("filter running without a good sample");
`endif

endmodule
